// File: rtl/core/ifpc_pkg.sv
`default_nettype none

package ifpc_pkg;

    // Frame constants
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  HDR_BYTE0 = 8'hA5;
    localparam logic [7:0]  HDR_BYTE1 = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE = 8'hFF;

    // Program geometry
    localparam int STEP_W     = 3;

    // Byte source for the current step
    typedef enum logic [2:0] {
        SEL_HDR0  = 3'd0,
        SEL_HDR1  = 3'd1,
        SEL_CHIDX = 3'd2,
        SEL_DATA  = 3'd3,
        SEL_CRCHI = 3'd4,
        SEL_CRCLO = 3'd5,
        SEL_TAIL  = 3'd6
    } sel_t;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_CNT_ZERO = 2'd1,
        COND_K_NOT2   = 2'd2,
        COND_MORE_CH  = 2'd3
    } cond_t;

    // Program step labels
    localparam logic [STEP_W-1:0] ST_HDR0  = 3'd0;
    localparam logic [STEP_W-1:0] ST_HDR1  = 3'd1;
    localparam logic [STEP_W-1:0] ST_CHIDX = 3'd2;
    localparam logic [STEP_W-1:0] ST_DATA  = 3'd3;
    localparam logic [STEP_W-1:0] ST_DATA3 = 3'd4;
    localparam logic [STEP_W-1:0] ST_CRCHI = 3'd5;
    localparam logic [STEP_W-1:0] ST_CRCLO = 3'd6;
    localparam logic [STEP_W-1:0] ST_TAIL  = 3'd7;

    // One control word
    typedef struct packed {
        sel_t              sel;
        logic              crc_en;
        logic              last;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              done;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic cnt_zero;
        logic k_not2;
        logic more_ch;
    } dp_stat_t;

    // Microprogram ROM
    function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{sel: SEL_TAIL, crc_en: 1'b0, last: 1'b0, cond: COND_NONE,
              target: ST_HDR0, done: 1'b0};
        case (step)
            ST_HDR0: begin
                w.sel = SEL_HDR0;  w.crc_en = 1'b1;
            end
            ST_HDR1: begin
                w.sel = SEL_HDR1;  w.crc_en = 1'b1;
                w.cond = COND_CNT_ZERO; w.target = ST_CRCHI;
            end
            ST_CHIDX: begin
                w.sel = SEL_CHIDX; w.crc_en = 1'b1;
            end
            ST_DATA: begin
                w.sel = SEL_DATA;  w.crc_en = 1'b1;
                w.cond = COND_K_NOT2; w.target = ST_DATA;
            end
            ST_DATA3: begin
                w.sel = SEL_DATA;  w.crc_en = 1'b1;
                w.cond = COND_MORE_CH; w.target = ST_CHIDX;
            end
            ST_CRCHI: w.sel = SEL_CRCHI;
            ST_CRCLO: w.sel = SEL_CRCLO;
            ST_TAIL: begin
                w.sel = SEL_TAIL;  w.last = 1'b1; w.done = 1'b1;
            end
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

    // CRC-16/MODBUS update by one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/imu_frame_packer_crc16_core.sv
// Channel  Dir  Transaction  Payload
// s_       in   frame req    tdata[1:0] count, [33:2] pitch, [65:34] yaw, [97:66] roll
// m_       out  frame byte   tdata[7:0] byte, tlast on trailing FF
//
// A frame of 5 + 5*count bytes leaves at one byte per cycle while m_tready does
// not stall it; the microprogram steps once per byte, the header, index and data
// steps also folding the byte into the CRC. A request is taken only when the
// sequencer is idle, once the previous frame's tail byte is in the output register.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid.
// A stall on m_tready holds the output byte and freezes the program step.
`default_nettype none

module imu_frame_packer_crc16_core
    import ifpc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // count[1:0], pitch, yaw, roll, zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // frame_byte[7:0]
    output logic              m_tlast
);

    ctrl_t    ctrl;
    dp_stat_t stat;
    logic     fire;
    logic     idle;
    logic     out_free;
    logic     start;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    // Microprogram sequencer
    ifpc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .fire     (fire),
        .idle     (idle)
    );

    // Byte datapath with CRC and output register
    ifpc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (start),
        .channel_count (s_tdata[1:0]),
        .pitch_bits    (s_tdata[33:2]),
        .yaw_bits      (s_tdata[65:34]),
        .roll_bits     (s_tdata[97:66]),
        .fire          (fire),
        .ctrl          (ctrl),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .out_free      (out_free),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// File: rtl/core/ifpc_seq.sv
`default_nettype none

module ifpc_seq
    import ifpc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     start,
    input  wire logic     out_free,
    input  wire dp_stat_t stat,
    output ctrl_t         ctrl,
    output logic          fire,
    output logic          idle
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              take_jump;

    // Fetch
    assign ctrl = prog_word(step_reg);
    assign fire = busy_reg && out_free;
    assign idle = !busy_reg;

    // Condition evaluation
    always_comb begin
        case (ctrl.cond)
            COND_NONE:     take_jump = 1'b0;
            COND_CNT_ZERO: take_jump = stat.cnt_zero;
            COND_K_NOT2:   take_jump = stat.k_not2;
            COND_MORE_CH:  take_jump = stat.more_ch;
            default:       take_jump = 1'b0;
        endcase
    end

    // Step counter and busy flag
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = ST_HDR0;
        end else if (fire) begin
            if (ctrl.done) begin
                busy_next = 1'b0;
                step_next = ST_HDR0;
            end else if (take_jump) begin
                step_next = ctrl.target;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= ST_HDR0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ifpc_dp.sv
`default_nettype none

module ifpc_dp
    import ifpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire logic [1:0]  channel_count,
    input  wire logic [31:0] pitch_bits,
    input  wire logic [31:0] yaw_bits,
    input  wire logic [31:0] roll_bits,
    input  wire logic        fire,
    input  wire ctrl_t       ctrl,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             out_free,
    output dp_stat_t         stat
);

    logic [31:0] pitch_reg, yaw_reg, roll_reg;
    logic [1:0]  count_reg;
    logic [1:0]  ch_reg, ch_next;
    logic [1:0]  k_reg, k_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [31:0] word;
    logic [7:0]  cur_byte;

    assign out_free = !valid_reg || m_tready;

    // Status for jumps
    assign stat.cnt_zero = (count_reg == 2'd0);
    assign stat.k_not2   = (k_reg != 2'd2);
    assign stat.more_ch  = ((ch_reg + 2'd1) != count_reg);

    // Byte select
    always_comb begin
        case (ch_reg)
            2'd0:    word = pitch_reg;
            2'd1:    word = yaw_reg;
            default: word = roll_reg;
        endcase
        case (ctrl.sel)
            SEL_HDR0:  cur_byte = HDR_BYTE0;
            SEL_HDR1:  cur_byte = HDR_BYTE1;
            SEL_CHIDX: cur_byte = {6'd0, ch_reg};
            SEL_DATA:  cur_byte = word[{k_reg, 3'b000} +: 8];
            SEL_CRCHI: cur_byte = crc_reg[15:8];
            SEL_CRCLO: cur_byte = crc_reg[7:0];
            SEL_TAIL:  cur_byte = TAIL_BYTE;
            default:   cur_byte = TAIL_BYTE;
        endcase
    end

    // Counters and CRC
    always_comb begin
        ch_next  = ch_reg;
        k_next   = k_reg;
        crc_next = crc_reg;
        if (load) begin
            ch_next  = 2'd0;
            k_next   = 2'd0;
            crc_next = CRC_INIT;
        end else if (fire) begin
            if (ctrl.crc_en) crc_next = crc16_byte(crc_reg, cur_byte);
            if (ctrl.sel == SEL_CHIDX) k_next = 2'd0;
            if (ctrl.sel == SEL_DATA) begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) ch_next = ch_reg + 2'd1;
            end
        end
    end

    // Output register valid
    always_comb begin
        valid_next = valid_reg;
        if (fire)          valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ch_reg    <= 2'd0;
            k_reg     <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            ch_reg    <= ch_next;
            k_reg     <= k_next;
        end
    end

    // Payload, CRC and output byte registers
    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (load) begin
            count_reg <= channel_count;
            pitch_reg <= pitch_bits;
            yaw_reg   <= yaw_bits;
            roll_reg  <= roll_bits;
        end
        if (fire) begin
            data_reg <= cur_byte;
            last_reg <= ctrl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/ifpc_checker.sv
`default_nettype none

module ifpc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [103:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [7:0]   m_tdata,
    input wire logic         m_tlast
);

    // Stalled output transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");

    // Nothing valid right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A request closes the input side once it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // The frame closes on the tail byte
    a_last_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'hFF)
        else $error("last byte is not the tail byte");

endmodule

bind imu_frame_packer_crc16_core ifpc_checker u_ifpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/imu_frame_packer_crc16_checker.sv
`default_nettype none

module imu_frame_packer_crc16_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,   // count[1:0], pitch, yaw, roll, zero pad
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [7:0]   m_tdata,   // frame_byte[7:0]
    input  wire logic         m_tlast,
    output int                fail_count,
    output int                bytes_pending,
    output int                frames_checked
);

    // Framing constants
    localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;
    localparam logic [7:0]  SYNC_A      = 8'hA5;
    localparam logic [7:0]  SYNC_B      = 8'h5A;
    localparam logic [7:0]  END_MARK    = 8'hFF;
    localparam int          PRINT_LIMIT = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       is_end;
    } frame_byte_t;

    frame_byte_t frame_bytes_due[$];
    logic [15:0] running_crc;
    int          byte_pos;

    initial begin
        fail_count     = 0;
        bytes_pending  = 0;
        frames_checked = 0;
        byte_pos       = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_LIMIT) begin
            $display("[%0t] frame %0d byte %0d: %s got %0h want %0h",
                     $time, frames_checked, byte_pos, what, got, want);
        end
        fail_count++;
    endtask

    // CRC-16/MODBUS, reflected, one bit per pass
    function automatic logic [15:0] modbus_fold(input logic [15:0] crc,
                                                input logic [7:0]  b);
        logic [15:0] r;
        logic        lsb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            lsb = r[0] ^ b[i];
            r   = {1'b0, r[15:1]};
            if (lsb) r = r ^ MODBUS_POLY;
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic covered, input logic is_end);
        frame_byte_t fb;
        fb.value  = b;
        fb.is_end = is_end;
        frame_bytes_due.push_back(fb);
        if (covered) running_crc = modbus_fold(running_crc, b);
    endtask

    // Build the expected byte stream for one frame request
    task automatic predict_frame(input logic [103:0] req);
        logic [1:0]  n_ch;
        logic [31:0] angle [3];
        n_ch     = req[1:0];
        angle[0] = req[33:2];
        angle[1] = req[65:34];
        angle[2] = req[97:66];
        running_crc = MODBUS_INIT;
        queue_byte(SYNC_A, 1'b1, 1'b0);
        queue_byte(SYNC_B, 1'b1, 1'b0);
        for (int ch = 0; ch < 3; ch++) begin
            if (ch < n_ch) begin
                queue_byte(8'(ch), 1'b1, 1'b0);
                for (int k = 0; k < 4; k++) queue_byte(angle[ch][8*k +: 8], 1'b1, 1'b0);
            end
        end
        queue_byte(running_crc[15:8], 1'b0, 1'b0);
        queue_byte(running_crc[7:0], 1'b0, 1'b0);
        queue_byte(END_MARK, 1'b0, 1'b1);
    endtask

    task automatic check_byte(input logic [7:0] b, input logic is_end);
        frame_byte_t want;
        if (frame_bytes_due.size() == 0) begin
            report_mismatch("unexpected byte", b, 0);
        end else begin
            want = frame_bytes_due.pop_front();
            if (b !== want.value) report_mismatch("frame_byte", b, want.value);
            if (is_end !== want.is_end) report_mismatch("frame_end", is_end, want.is_end);
        end
        if (is_end === 1'b1) begin
            frames_checked++;
            byte_pos = 0;
        end else begin
            byte_pos++;
        end
    endtask

    // Track both channels at each rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_frame(s_tdata);
            if (m_tvalid && m_tready) check_byte(m_tdata, m_tlast);
            bytes_pending = frame_bytes_due.size();
        end
    end

endmodule

`default_nettype wire

// File: verif/imu_frame_packer_crc16_core_test.sv
`default_nettype none

module imu_frame_packer_crc16_core_test;

    localparam int RANDOM_REQS   = 250;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 25;
    localparam int STEADY_FIRST  = 100;
    localparam int STEADY_LAST   = 159;
    localparam int DRAIN_AT      = 200;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // count[1:0], pitch, yaw, roll, zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // frame_byte[7:0]
    logic         m_tlast;

    int fail_count;
    int bytes_pending;
    int frames_checked;
    int stall_cycles;
    int reqs_sent;
    int count_seen [4];
    bit steady;

    imu_frame_packer_crc16_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    imu_frame_packer_crc16_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .bytes_pending  (bytes_pending),
        .frames_checked (frames_checked)
    );

    // Clock, period 2
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("imu_frame_packer_crc16_core_test: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] random_angle();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(input logic [1:0] n_ch, input logic [31:0] pitch,
                                input logic [31:0] yaw, input logic [31:0] roll);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, roll, yaw, pitch, n_ch};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        reqs_sent++;
        count_seen[n_ch]++;
    endtask

    // Hold off the sender until every frame byte has come out
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (bytes_pending != 0) @(negedge aclk);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        steady       = 1'b0;
        stall_cycles = 0;
        reqs_sent    = 0;
        for (int i = 0; i < 4; i++) count_seen[i] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty frames, word extremes, unused channels carrying data
        send_request(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(2'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(2'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(2'd1, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
        send_request(2'd2, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(2'd2, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000);
        send_request(2'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(2'd3, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(2'd3, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C);
        send_request(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_request(2'd3, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000);
        drain_frames();

        // Random frame requests
        for (int i = 0; i < RANDOM_REQS; i++) begin
            steady = (i >= STEADY_FIRST) && (i <= STEADY_LAST);
            if (i == DRAIN_AT) drain_frames();
            send_request(2'($urandom_range(0, 3)), random_angle(), random_angle(),
                         random_angle());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Wait out the last frame, then watch for stray bytes
        while (bytes_pending != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("sent %0d frame requests (channel counts 0/1/2/3: %0d/%0d/%0d/%0d)",
                 reqs_sent, count_seen[0], count_seen[1], count_seen[2], count_seen[3]);
        $display("checked %0d frames byte by byte under random stalls on both sides",
                 frames_checked);
        if (fail_count == 0) begin
            $display("imu_frame_packer_crc16_core_test: clean");
        end else begin
            $display("imu_frame_packer_crc16_core_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/ifpc_pkg.sv
rtl/core/ifpc_seq.sv
rtl/core/ifpc_dp.sv
rtl/core/imu_frame_packer_crc16_core.sv
rtl/core/ifpc_checker.sv
verif/imu_frame_packer_crc16_checker.sv
verif/imu_frame_packer_crc16_core_test.sv
